// File: src/smm_pkg.sv
package smm_pkg;

  // fixed field widths of the item ports
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DIM_W  = 4;
  localparam int unsigned DATA_W = 32;

  // input opcodes, code 3 has no meaning and is dropped
  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } smm_op_t;

  // tag that travels with each product term through the pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             fin;
    logic             last;
  } smm_tag_t;

endpackage

// File: src/square_matrix_multiply_core.sv
// Square integer matrix multiplier. Two MAX_DIM x MAX_DIM stores hold A and B;
// a load beat (opcode 0 or 1) writes one element, and loads with
// row or col outside the store are dropped. A compute beat (opcode 2) runs
// N^3 multiply-accumulates on a single 32x32 multiplier and adder, one term per
// cycle while the result side does not stall, and emits C = A * B in row-major
// order with out_last on the final element. That one shared multiply-accumulate
// unit is fed by one read port per store. in_stall stays high for the whole run.
// The dimension N comes from cfg_wr_data
// (reset 8, zero reads as 1, values above MAX_DIM clamp to MAX_DIM) and may
// only be written while idle. Store entries are undefined until loaded; every
// element that a compute reads must have been written first. Sums wrap mod 2^32.
module square_matrix_multiply_core #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [smm_pkg::DIM_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [smm_pkg::IDX_W-1:0]     in_row,
  input  logic [smm_pkg::IDX_W-1:0]     in_col,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [smm_pkg::IDX_W-1:0]     out_row,
  output logic [smm_pkg::IDX_W-1:0]     out_col,
  output logic signed [31:0]            out_product,
  output logic                          out_last
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [smm_pkg::DIM_W-1:0]    size_r;
  logic [smm_pkg::DIM_W-1:0]    dim_eff;
  logic                         busy_r, busy_nxt;
  logic                         in_acc;
  logic                         pipe_en;
  logic                         in_range;
  logic                         load_a, load_b, start;
  logic [ADDR_W-1:0]            wr_addr;
  logic [ADDR_W-1:0]            a_addr, b_addr;
  logic [smm_pkg::DATA_W-1:0]   a_data, b_data;
  smm_pkg::smm_tag_t            rd_tag;
  smm_pkg::smm_tag_t            res_tag;
  logic                         res_valid;
  logic [smm_pkg::DATA_W-1:0]   res_value;
  logic                         out_valid_r, out_valid_nxt;
  logic [smm_pkg::IDX_W-1:0]    out_row_r;
  logic [smm_pkg::IDX_W-1:0]    out_col_r;
  logic [smm_pkg::DATA_W-1:0]   out_product_r;
  logic                         out_last_r;

  // dimension register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= smm_pkg::DIM_W'(8);
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  assign dim_eff = (size_r == '0) ? smm_pkg::DIM_W'(1) :
                   (size_r > smm_pkg::DIM_W'(MAX_DIM)) ? smm_pkg::DIM_W'(MAX_DIM) :
                   size_r;

  // input beat decode
  assign in_acc   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign in_range = ({1'b0, in_row} < smm_pkg::DIM_W'(MAX_DIM)) &&
                    ({1'b0, in_col} < smm_pkg::DIM_W'(MAX_DIM));
  assign load_a   = in_acc && in_range && (in_opcode == smm_pkg::OP_LOAD_A);
  assign load_b   = in_acc && in_range && (in_opcode == smm_pkg::OP_LOAD_B);
  assign start    = in_acc && (in_opcode == smm_pkg::OP_COMPUTE);
  assign wr_addr  = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));

  // whole pipeline holds while a finished result is still waiting
  assign pipe_en = !out_valid_r || !out_stall;

  smm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (load_a),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (pipe_en),
    .rd_addr (a_addr),
    .rd_data (a_data)
  );

  smm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (load_b),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (pipe_en),
    .rd_addr (b_addr),
    .rd_data (b_data)
  );

  smm_seq #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .dim    (dim_eff),
    .en     (pipe_en),
    .a_addr (a_addr),
    .b_addr (b_addr),
    .tag    (rd_tag)
  );

  smm_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .tag_in    (rd_tag),
    .a         (a_data),
    .b         (b_data),
    .res_tag   (res_tag),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  // busy from compute accept until the last element reaches the output
  always_comb begin
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (pipe_en && res_valid && res_tag.last) begin
      busy_nxt = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pipe_en) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && res_valid) begin
      out_row_r     <= res_tag.row;
      out_col_r     <= res_tag.col;
      out_product_r <= res_value;
      out_last_r    <= res_tag.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_product = out_product_r;
  assign out_last    = out_last_r;

  // a compute beat always makes the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("compute accepted without going busy");

  // product terms only flow while a run is in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_tag.valid |-> busy_r)
    else $error("read beat outside a compute run");

  // the final element ends the run
  assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_en && res_valid && res_tag.last) |=> (!in_stall && out_valid && out_last))
    else $error("run did not end on the last element");

endmodule

// File: src/smm_store.sv
module smm_store #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [smm_pkg::DATA_W-1:0]     wr_data,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  output logic [smm_pkg::DATA_W-1:0]     rd_data
);

  logic [smm_pkg::DATA_W-1:0] mem [DEPTH];
  logic [smm_pkg::DATA_W-1:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/smm_seq.sv
module smm_seq #(
  parameter int unsigned MAX_DIM = 8,
  parameter int unsigned ADDR_W  = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [smm_pkg::DIM_W-1:0]     dim,
  input  logic                          en,
  output logic [ADDR_W-1:0]             a_addr,
  output logic [ADDR_W-1:0]             b_addr,
  output smm_pkg::smm_tag_t             tag
);

  logic                          active_r, active_nxt;
  logic [smm_pkg::IDX_W-1:0]     i_r, i_nxt;
  logic [smm_pkg::IDX_W-1:0]     j_r, j_nxt;
  logic [smm_pkg::IDX_W-1:0]     k_r, k_nxt;
  logic [smm_pkg::DIM_W-1:0]     n_r, n_nxt;
  smm_pkg::smm_tag_t             tag_r, tag_nxt;
  logic [smm_pkg::DIM_W-1:0]     top_idx;
  logic                          k_end, j_end, i_end;

  assign top_idx = n_r - smm_pkg::DIM_W'(1);
  assign k_end   = ({1'b0, k_r} == top_idx);
  assign j_end   = ({1'b0, j_r} == top_idx);
  assign i_end   = ({1'b0, i_r} == top_idx);

  // operand addresses A[i][k] and B[k][j]
  assign a_addr = ADDR_W'(int'(i_r) * MAX_DIM + int'(k_r));
  assign b_addr = ADDR_W'(int'(k_r) * MAX_DIM + int'(j_r));

  // i, j, k loop counters, k innermost
  always_comb begin
    active_nxt = active_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    tag_nxt    = tag_r;
    if (en) begin
      tag_nxt.valid = active_r;
      tag_nxt.row   = i_r;
      tag_nxt.col   = j_r;
      tag_nxt.first = (k_r == '0);
      tag_nxt.fin   = k_end;
      tag_nxt.last  = i_end && j_end;
      if (active_r) begin
        if (k_end) begin
          k_nxt = '0;
          if (j_end) begin
            j_nxt = '0;
            if (i_end) begin
              active_nxt = 1'b0;
            end else begin
              i_nxt = i_r + smm_pkg::IDX_W'(1);
            end
          end else begin
            j_nxt = j_r + smm_pkg::IDX_W'(1);
          end
        end else begin
          k_nxt = k_r + smm_pkg::IDX_W'(1);
        end
      end
    end
    if (start) begin
      active_nxt = 1'b1;
      i_nxt      = '0;
      j_nxt      = '0;
      k_nxt      = '0;
      n_nxt      = dim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tag_r    <= '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      n_r      <= smm_pkg::DIM_W'(1);
    end else begin
      active_r <= active_nxt;
      tag_r    <= tag_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      n_r      <= n_nxt;
    end
  end

  // tag lines up with the registered store read data
  assign tag = tag_r;

endmodule

// File: src/smm_mac.sv
module smm_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  smm_pkg::smm_tag_t             tag_in,
  input  logic [smm_pkg::DATA_W-1:0]    a,
  input  logic [smm_pkg::DATA_W-1:0]    b,
  output smm_pkg::smm_tag_t             res_tag,
  output logic                          res_valid,
  output logic [smm_pkg::DATA_W-1:0]    res_value
);

  localparam int unsigned PROD_W = 2 * smm_pkg::DATA_W;

  logic [smm_pkg::DATA_W-1:0] prod_r;
  logic [smm_pkg::DATA_W-1:0] acc_r;
  smm_pkg::smm_tag_t          tag_r;
  logic [PROD_W-1:0]          prod_full;
  logic [smm_pkg::DATA_W-1:0] sum;

  // low half of the product is all that survives the wrap
  assign prod_full = a * b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_full[smm_pkg::DATA_W-1:0];
    end
  end

  // accumulate, restarting on the first term of each element
  assign sum = (tag_r.first ? '0 : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (en && tag_r.valid) begin
      acc_r <= sum;
    end
  end

  assign res_tag   = tag_r;
  assign res_valid = tag_r.valid && tag_r.fin;
  assign res_value = sum;

endmodule
